// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DLS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dls: check failed");

// next-cycle implication
`define DLS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dls: check failed");

`endif

// ----- rtl/dls_pkg.sv -----
// ---------------------------------------------------------------------------
// Loss scaler package
// Shared widths, codes, types and fp32 helpers.
// ---------------------------------------------------------------------------
package dls_pkg;

   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 72;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] FUNC_SCALE   = 2'd0;
   localparam logic [1:0] FUNC_UNSCALE = 2'd1;
   localparam logic [1:0] FUNC_STEP    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_SCALE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROW       = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHRINK     = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS      = 4'd3;

   localparam logic FPU_OP_MUL   = 1'b0;
   localparam logic FPU_OP_RECIP = 1'b1;

   localparam logic [31:0] FP_DEF_SCALE  = 32'h4780_0000;
   localparam logic [31:0] FP_DEF_INV    = 32'h3780_0000;
   localparam logic [31:0] FP_DEF_GROW   = 32'h4000_0000;
   localparam logic [31:0] FP_DEF_SHRINK = 32'h3F00_0000;
   localparam logic [31:0] FP_ONE        = 32'h3F80_0000;
   localparam logic [31:0] FP_MAX_SCALE  = 32'h4F80_0000;
   localparam logic [31:0] FP_QNAN       = 32'h7FC0_0000;
   localparam logic [31:0] FP_DEF_NAN    = 32'hFFC0_0000;
   localparam logic [31:0] FP_QUIET_BIT  = 32'h0040_0000;
   localparam logic [15:0] DEF_STEPS     = 16'd2000;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] value;
      logic        first;
   } item_type;

   typedef struct packed {
      logic        start;
      logic        op;
      logic [31:0] a;
      logic [31:0] b;
   } fpu_req_type;

   function automatic logic nonfinite(input logic [31:0] x);
      return x[30:23] == 8'hFF;
   endfunction

   function automatic logic is_nan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic [31:0] canon(input logic [31:0] x);
      return is_nan(x) ? FP_QNAN : x;
   endfunction

   function automatic logic [31:0] pick(input logic [31:0] x, input logic [31:0] dflt);
      return (!x[31] && (x[30:0] != 31'd0) && !is_nan(x)) ? x : dflt;
   endfunction

   function automatic logic lt_one(input logic [31:0] x);
      return !is_nan(x) && (x[31] || (x[30:0] < FP_ONE[30:0]));
   endfunction

   function automatic logic gt_max(input logic [31:0] x);
      return !is_nan(x) && !x[31] && (x[30:0] > FP_MAX_SCALE[30:0]);
   endfunction

endpackage

// ----- rtl/dls_front.sv -----
// ---------------------------------------------------------------------------
// Loss scaler front end
// Takes request beats and holds them in a short queue for the back end.
// ---------------------------------------------------------------------------
module dls_front #(
   parameter int QUEUE_DEPTH = dls_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dls_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [dls_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            q_valid,
   output dls_pkg::item_type               q_item,
   input  logic                            q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   dls_pkg::item_type     buf_ff [QUEUE_DEPTH];
   dls_pkg::item_type     push_item;
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  push, pop;

   assign req_tready = cnt_ff != CNT_W'(QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = cnt_ff != '0;
   assign pop        = q_pop && q_valid;
   assign q_item     = buf_ff[rd_ptr_ff];

   always_comb begin
      push_item.func  = req_tuser[1:0];
      push_item.value = req_tdata[31:0];
      push_item.first = req_tdata[32];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/dls_fpu.sv -----
// ---------------------------------------------------------------------------
// Loss scaler fp32 unit
// Multi-cycle fp32 multiply and reciprocal, round to nearest even,
// subnormals kept. Reciprocal runs a restoring divider, one bit a cycle.
// ---------------------------------------------------------------------------
module dls_fpu (
   input  logic                 clock,
   input  logic                 reset,
   input  dls_pkg::fpu_req_type req,
   output logic                 done,
   output logic [31:0]          result
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_NORM  = 3'd2;
   localparam logic [2:0] S_ROUND = 3'd3;

   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      n = '0;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) n = 5'(23 - i);
      end
      return n;
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) n = 6'(47 - i);
      end
      return n;
   endfunction

   logic [2:0]         state_ff, state_in;
   logic               sign_ff, sign_in;
   logic [47:0]        p_ff, p_in;
   logic signed [10:0] x_ff, x_in;
   logic               stk_ff, stk_in;
   logic [23:0]        rem_ff, rem_in;
   logic [23:0]        ms_ff, ms_in;
   logic [24:0]        q_ff, q_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [47:0]        m_ff, m_in;
   logic signed [10:0] re_ff, re_in;
   logic [31:0]        result_ff, result_in;
   logic               done_ff, done_in;

   logic        a_zero, a_inf, a_nan, b_zero, b_inf, b_nan, sgn;
   logic [23:0] a_sig, b_sig;
   logic [7:0]  a_ee, b_ee;
   logic [4:0]  lz_a;
   logic [5:0]  lz_p;
   logic [24:0] rem2;
   logic        ge;
   logic signed [10:0] sh;
   logic [47:0] m2;
   logic        lost, rnd;
   logic [7:0]  e_f;
   logic [30:0] mag;

   always_comb begin
      a_zero = (req.a[30:23] == 8'd0) && (req.a[22:0] == 23'd0);
      a_inf  = (req.a[30:23] == 8'hFF) && (req.a[22:0] == 23'd0);
      a_nan  = dls_pkg::is_nan(req.a);
      b_zero = (req.b[30:23] == 8'd0) && (req.b[22:0] == 23'd0);
      b_inf  = (req.b[30:23] == 8'hFF) && (req.b[22:0] == 23'd0);
      b_nan  = dls_pkg::is_nan(req.b);
      a_sig  = {req.a[30:23] != 8'd0, req.a[22:0]};
      b_sig  = {req.b[30:23] != 8'd0, req.b[22:0]};
      a_ee   = (req.a[30:23] == 8'd0) ? 8'd1 : req.a[30:23];
      b_ee   = (req.b[30:23] == 8'd0) ? 8'd1 : req.b[30:23];
      lz_a   = lzc24(a_sig);
      sgn    = (req.op == dls_pkg::FPU_OP_MUL) ? (req.a[31] ^ req.b[31]) : req.a[31];

      rem2 = {rem_ff, 1'b0};
      ge   = rem2 >= {1'b0, ms_ff};
      lz_p = lzc48(p_ff);

      sh   = 11'sd1 - re_ff;
      m2   = m_ff;
      lost = 1'b0;
      e_f  = re_ff[7:0];
      if (re_ff < 11'sd1) begin
         e_f = 8'd0;
         if (sh > 11'sd47) begin
            m2   = '0;
            lost = m_ff != '0;
         end else begin
            m2   = m_ff >> sh[5:0];
            lost = (m_ff & ~({48{1'b1}} << sh[5:0])) != '0;
         end
      end
      rnd = m2[23] & (m2[24] | (m2[22:0] != 23'd0) | lost | stk_ff);
      mag = {e_f, m2[46:24]} + 31'(rnd);

      state_in  = state_ff;
      sign_in   = sign_ff;
      p_in      = p_ff;
      x_in      = x_ff;
      stk_in    = stk_ff;
      rem_in    = rem_ff;
      ms_in     = ms_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      m_in      = m_ff;
      re_in     = re_ff;
      result_in = result_ff;
      done_in   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               sign_in = sgn;
               stk_in  = 1'b0;
               if (req.op == dls_pkg::FPU_OP_MUL) begin
                  done_in = 1'b1;
                  if (a_nan) begin
                     result_in = req.a | dls_pkg::FP_QUIET_BIT;
                  end else if (b_nan) begin
                     result_in = req.b | dls_pkg::FP_QUIET_BIT;
                  end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                     result_in = dls_pkg::FP_DEF_NAN;
                  end else if (a_inf || b_inf) begin
                     result_in = {sgn, 8'hFF, 23'd0};
                  end else if (a_zero || b_zero) begin
                     result_in = {sgn, 31'd0};
                  end else begin
                     done_in  = 1'b0;
                     p_in     = a_sig * b_sig;
                     x_in     = $signed({3'b0, a_ee}) + $signed({3'b0, b_ee}) - 11'sd127;
                     state_in = S_NORM;
                  end
               end else begin
                  done_in = 1'b1;
                  if (a_nan) begin
                     result_in = req.a | dls_pkg::FP_QUIET_BIT;
                  end else if (a_inf) begin
                     result_in = {sgn, 31'd0};
                  end else if (a_zero) begin
                     result_in = {sgn, 8'hFF, 23'd0};
                  end else begin
                     done_in  = 1'b0;
                     ms_in    = a_sig << lz_a;
                     x_in     = 11'sd253 - $signed({3'b0, a_ee}) + $signed({6'b0, lz_a});
                     rem_in   = 24'd1;
                     q_in     = '0;
                     cnt_in   = '0;
                     state_in = S_DIV;
                  end
               end
            end
         end
         S_DIV: begin
            rem_in = ge ? 24'(rem2 - {1'b0, ms_ff}) : rem2[23:0];
            q_in   = {q_ff[23:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd47) begin
               p_in     = {q_ff[24:0], ge, 22'd0};
               stk_in   = ge ? (24'(rem2 - {1'b0, ms_ff}) != 24'd0) : (rem2[23:0] != 24'd0);
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            m_in     = p_ff << lz_p;
            re_in    = x_ff + 11'sd1 - $signed({5'b0, lz_p});
            state_in = S_ROUND;
         end
         S_ROUND: begin
            done_in   = 1'b1;
            result_in = (re_ff >= 11'sd255) ? {sign_ff, 8'hFF, 23'd0} : {sign_ff, mag};
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff   <= sign_in;
      p_ff      <= p_in;
      x_ff      <= x_in;
      stk_ff    <= stk_in;
      rem_ff    <= rem_in;
      ms_ff     <= ms_in;
      q_ff      <= q_in;
      cnt_ff    <= cnt_in;
      m_ff      <= m_in;
      re_ff     <= re_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ----- rtl/dls_back.sv -----
// ---------------------------------------------------------------------------
// Loss scaler back end
// Sequences each queued item, through the fp32 unit where it needs one, keeps
// scale state and the control registers, and drives the response register.
// ---------------------------------------------------------------------------
module dls_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  dls_pkg::item_type               q_item,
   output logic                            q_pop,
   input  logic                            csr_wr_en,
   input  logic [dls_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dls_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output dls_pkg::fpu_req_type            fpu_req,
   input  logic                            fpu_done,
   input  logic [31:0]                     fpu_result,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dls_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_ELEM = 3'd1;
   localparam logic [2:0] B_SMUL = 3'd2;
   localparam logic [2:0] B_REC  = 3'd3;
   localparam logic [2:0] B_WR   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] scale_ff, scale_in;
   logic [31:0] inv_ff, inv_in;
   logic [15:0] count_ff, count_in;
   logic        bad_ff, bad_in;
   logic [31:0] grow_ff, grow_in;
   logic [31:0] shrink_ff, shrink_in;
   logic [15:0] steps_ff, steps_in;
   logic        rec_pend_ff, rec_pend_in;
   logic        from_item_ff, from_item_in;
   logic        unscale_ff, unscale_in;
   logic        shrink_sel_ff, shrink_sel_in;
   logic [31:0] vout_ff, vout_in;
   logic        ebad_ff, ebad_in;
   logic        go_ff, go_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [dls_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [15:0] need, cnt_nx;
   logic [31:0] s_clamp;
   logic        out_free;

   always_comb begin
      need     = (steps_ff == 16'd0) ? dls_pkg::DEF_STEPS : steps_ff;
      cnt_nx   = count_ff + 16'd1;
      out_free = !rsp_valid_ff || rsp_tready;
      if (shrink_sel_ff) begin
         s_clamp = dls_pkg::lt_one(fpu_result) ? dls_pkg::FP_ONE : fpu_result;
      end else begin
         s_clamp = dls_pkg::gt_max(fpu_result) ? dls_pkg::FP_MAX_SCALE : fpu_result;
      end

      state_in      = state_ff;
      scale_in      = scale_ff;
      inv_in        = inv_ff;
      count_in      = count_ff;
      bad_in        = bad_ff;
      grow_in       = grow_ff;
      shrink_in     = shrink_ff;
      steps_in      = steps_ff;
      rec_pend_in   = rec_pend_ff;
      from_item_in  = from_item_ff;
      unscale_in    = unscale_ff;
      shrink_sel_in = shrink_sel_ff;
      vout_in       = vout_ff;
      ebad_in       = ebad_ff;
      go_in         = go_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      fpu_req       = '0;

      unique case (state_ff)
         B_IDLE: begin
            if (rec_pend_ff) begin
               rec_pend_in   = 1'b0;
               fpu_req.start = 1'b1;
               fpu_req.op    = dls_pkg::FPU_OP_RECIP;
               fpu_req.a     = scale_ff;
               state_in      = B_REC;
            end else if (q_valid) begin
               q_pop      = 1'b1;
               vout_in    = '0;
               ebad_in    = 1'b0;
               go_in      = 1'b0;
               unscale_in = q_item.func == dls_pkg::FUNC_UNSCALE;
               if (q_item.func == dls_pkg::FUNC_SCALE) begin
                  fpu_req.start = 1'b1;
                  fpu_req.op    = dls_pkg::FPU_OP_MUL;
                  fpu_req.a     = q_item.value;
                  fpu_req.b     = scale_ff;
                  state_in      = B_ELEM;
               end else if (q_item.func == dls_pkg::FUNC_UNSCALE) begin
                  if (q_item.first) bad_in = 1'b0;
                  fpu_req.start = 1'b1;
                  fpu_req.op    = dls_pkg::FPU_OP_MUL;
                  fpu_req.a     = q_item.value;
                  fpu_req.b     = inv_ff;
                  state_in      = B_ELEM;
               end else if (q_item.func == dls_pkg::FUNC_STEP) begin
                  go_in  = !bad_ff;
                  bad_in = 1'b0;
                  fpu_req.op = dls_pkg::FPU_OP_MUL;
                  fpu_req.a  = scale_ff;
                  if (bad_ff) begin
                     count_in      = '0;
                     shrink_sel_in = 1'b1;
                     fpu_req.start = 1'b1;
                     fpu_req.b     = dls_pkg::pick(shrink_ff, dls_pkg::FP_DEF_SHRINK);
                     state_in      = B_SMUL;
                  end else if (cnt_nx >= need) begin
                     count_in      = '0;
                     shrink_sel_in = 1'b0;
                     fpu_req.start = 1'b1;
                     fpu_req.b     = dls_pkg::pick(grow_ff, dls_pkg::FP_DEF_GROW);
                     state_in      = B_SMUL;
                  end else begin
                     count_in = cnt_nx;
                     state_in = B_WR;
                  end
               end else begin
                  state_in = B_WR;
               end
            end
         end
         B_ELEM: begin
            if (fpu_done) begin
               vout_in = dls_pkg::canon(fpu_result);
               if (unscale_ff && dls_pkg::nonfinite(fpu_result)) begin
                  ebad_in = 1'b1;
                  bad_in  = 1'b1;
               end
               state_in = B_WR;
            end
         end
         B_SMUL: begin
            if (fpu_done) begin
               scale_in     = s_clamp;
               rec_pend_in  = 1'b1;
               from_item_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         B_REC: begin
            if (fpu_done) begin
               inv_in       = fpu_result;
               from_item_in = 1'b0;
               state_in     = from_item_ff ? B_WR : B_IDLE;
            end
         end
         B_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, scale_ff, go_ff, bad_ff, ebad_ff, vout_ff};
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         priority if (csr_index == dls_pkg::CSR_INIT_SCALE) begin
            scale_in    = dls_pkg::pick(csr_wdata, dls_pkg::FP_DEF_SCALE);
            rec_pend_in = 1'b1;
         end else if (csr_index == dls_pkg::CSR_GROW) begin
            grow_in = csr_wdata;
         end else if (csr_index == dls_pkg::CSR_SHRINK) begin
            shrink_in = csr_wdata;
         end else if (csr_index == dls_pkg::CSR_STEPS) begin
            steps_in = csr_wdata[15:0];
         end else begin
            steps_in = steps_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         scale_ff      <= dls_pkg::FP_DEF_SCALE;
         inv_ff        <= dls_pkg::FP_DEF_INV;
         count_ff      <= '0;
         bad_ff        <= 1'b0;
         grow_ff       <= dls_pkg::FP_DEF_GROW;
         shrink_ff     <= dls_pkg::FP_DEF_SHRINK;
         steps_ff      <= dls_pkg::DEF_STEPS;
         rec_pend_ff   <= 1'b0;
         from_item_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scale_ff      <= scale_in;
         inv_ff        <= inv_in;
         count_ff      <= count_in;
         bad_ff        <= bad_in;
         grow_ff       <= grow_in;
         shrink_ff     <= shrink_in;
         steps_ff      <= steps_in;
         rec_pend_ff   <= rec_pend_in;
         from_item_ff  <= from_item_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      unscale_ff    <= unscale_in;
      shrink_sel_ff <= shrink_sel_in;
      vout_ff       <= vout_in;
      ebad_ff       <= ebad_in;
      go_ff         <= go_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/dynamic_loss_scaler.sv -----
// ---------------------------------------------------------------------------
// Dynamic loss scaler
// fp32 loss scaling, gradient unscaling with overflow detection, and
// per-step scale backoff and growth.
// ---------------------------------------------------------------------------
// One item is worked at a time. A scale or unscale beat goes from the queue
// to the response register through one fp32 multiply, then normalise and
// round stages. An end-of-step beat that changes the scale runs the scale
// multiply, then the reciprocal, which runs a restoring divider at one
// quotient bit a cycle. A write to initial_scale starts the same reciprocal,
// and items wait behind it. The request queue keeps taking beats, until it
// is full, while the back end works or a response waits.
module dynamic_loss_scaler #(
   parameter int QUEUE_DEPTH = dls_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // value_in [31:0], first_of_pass [32]
   input  logic [dls_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func [1:0]
   input  logic [dls_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // value_out [31:0], element_bad [32], inf_seen [33], optimizer_go [34],
   // scale_now [66:35]
   output logic [dls_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [dls_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dls_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                 q_valid, q_pop;
   dls_pkg::item_type    q_item;
   dls_pkg::fpu_req_type fpu_req;
   logic                 fpu_done;
   logic [31:0]          fpu_result;

   dls_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   dls_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .req    (fpu_req),
      .done   (fpu_done),
      .result (fpu_result)
   );

   dls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fpu_req    (fpu_req),
      .fpu_done   (fpu_done),
      .fpu_result (fpu_result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/dls_checker.sv -----
// ---------------------------------------------------------------------------
// Loss scaler port checker
// Port-level checks on the response stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dls_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dls_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // stalled response beat holds
   `DLS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a bad element is nonfinite and marks the sticky flag
   `DLS_ASSERT_NOW(a_bad_nonfinite, rsp_tvalid && rsp_tdata[32], rsp_tdata[30:23] == 8'hFF)
   `DLS_ASSERT_NOW(a_bad_sticky, rsp_tvalid && rsp_tdata[32], rsp_tdata[33])

   // optimizer go only on a clean end-of-step beat
   `DLS_ASSERT_NOW(a_go_clean, rsp_tvalid && rsp_tdata[34], !rsp_tdata[33] && !rsp_tdata[32])
   `DLS_ASSERT_NOW(a_go_zero, rsp_tvalid && rsp_tdata[34], rsp_tdata[31:0] == 32'd0)

endmodule

bind dynamic_loss_scaler dls_checker u_dls_checker (.*);
